// ===== rtl/sva_pkg.sv =====
// Shared types and constants for the synth voice allocator.
// Used by sva_cell and synth_voice_allocator_core; no dependencies.
`timescale 1ns / 1ps

package sva_pkg;

   localparam int NUM_VOICES_DEF = 8;
   localparam int AGE_W          = 32;
   localparam int NOTE_W         = 7;
   localparam int VEL_W          = 7;
   localparam int CSR_W          = 4;
   localparam int MASK_W         = 8;
   localparam int UNI_MAX        = 8;

   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_ALL_OFF  = 2'd2,
      CMD_FINISHED = 2'd3
   } sva_cmd_type;

   typedef enum logic [1:0] {
      ACT_START    = 2'd0,
      ACT_RELEASE  = 2'd1,
      ACT_KILL_ALL = 2'd2
   } sva_action_type;

   typedef enum logic [1:0] {
      MODE_POLY    = 2'd0,
      MODE_MONO    = 2'd1,
      MODE_LEGATO  = 2'd2,
      MODE_UNISON  = 2'd3
   } sva_mode_type;

   typedef enum logic [1:0] {
      CSR_VOICE_MODE   = 2'd0,
      CSR_UNISON_COUNT = 2'd1,
      CSR_GLIDE_ON     = 2'd2,
      CSR_GLIDE_HELD   = 2'd3
   } sva_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } sva_state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              wr_en;
      logic              clr_all;
      logic              note_off;
      logic              finish;
      logic [NOTE_W-1:0] note;
      logic [AGE_W-1:0]  age;
   } sva_ctl_type;

   // running search result handed from cell to cell
   typedef struct packed {
      logic             free_found;
      logic             rel_found;
      logic [AGE_W-1:0] rel_age;
      logic [AGE_W-1:0] all_age;
   } sva_cand_type;

   typedef struct packed {
      logic used;
      logic gate;
      logic off_hit;
   } sva_stat_type;

endpackage

// ===== rtl/sva_cell.sv =====
// One voice slot: used/gate/note/age state plus one stage of the
// free / oldest-released / oldest search chain. Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_cell #(
   parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF,
   parameter int CELL_ID    = 0,
   localparam int IDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sva_pkg::sva_ctl_type  ctl,
   input  logic                  wr_sel,
   input  logic                  fin_sel,
   input  sva_pkg::sva_cand_type cand_i,
   input  logic [IDX_W-1:0]      free_idx_i,
   input  logic [IDX_W-1:0]      rel_idx_i,
   input  logic [IDX_W-1:0]      all_idx_i,
   output sva_pkg::sva_cand_type cand_o,
   output logic [IDX_W-1:0]      free_idx_o,
   output logic [IDX_W-1:0]      rel_idx_o,
   output logic [IDX_W-1:0]      all_idx_o,
   output sva_pkg::sva_stat_type stat_o
);
   import sva_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

   logic              used_ff, used_in;
   logic              gate_ff, gate_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic              off_hit;

   sva_cand_type      cand_ff, cand_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  rel_idx_ff, rel_idx_in;
   logic [IDX_W-1:0]  all_idx_ff, all_idx_in;

   assign off_hit = ctl.note_off && used_ff && gate_ff && (note_ff == ctl.note);

   always_comb begin
      used_in = used_ff;
      gate_in = gate_ff;
      note_in = note_ff;
      age_in  = age_ff;
      if (ctl.wr_en && wr_sel) begin
         used_in = 1'b1;
         gate_in = 1'b1;
         note_in = ctl.note;
         age_in  = ctl.age;
      end else if (ctl.clr_all) begin
         used_in = 1'b0;
         gate_in = 1'b0;
      end else if (off_hit) begin
         gate_in = 1'b0;
      end else if (ctl.finish && fin_sel && used_ff && !gate_ff) begin
         used_in = 1'b0;
      end
   end

   // search stage; strict compares keep the lower voice on equal age
   always_comb begin
      cand_in     = cand_i;
      free_idx_in = free_idx_i;
      rel_idx_in  = rel_idx_i;
      all_idx_in  = all_idx_i;
      if (!cand_i.free_found && !used_ff) begin
         cand_in.free_found = 1'b1;
         free_idx_in        = MY_IDX;
      end
      if (!gate_ff && (!cand_i.rel_found || (age_ff < cand_i.rel_age))) begin
         cand_in.rel_found = 1'b1;
         cand_in.rel_age   = age_ff;
         rel_idx_in        = MY_IDX;
      end
      if (age_ff < cand_i.all_age) begin
         cand_in.all_age = age_ff;
         all_idx_in      = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         gate_ff <= 1'b0;
         age_ff  <= '0;
         cand_ff <= '0;
      end else begin
         used_ff <= used_in;
         gate_ff <= gate_in;
         age_ff  <= age_in;
         cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff         <= note_in;
      free_idx_ff     <= free_idx_in;
      rel_idx_ff      <= rel_idx_in;
      all_idx_ff      <= all_idx_in;
   end

   assign cand_o         = cand_ff;
   assign free_idx_o     = free_idx_ff;
   assign rel_idx_o      = rel_idx_ff;
   assign all_idx_o      = all_idx_ff;
   assign stat_o.used    = used_ff;
   assign stat_o.gate    = gate_ff;
   assign stat_o.off_hit = off_hit;

endmodule

// ===== rtl/synth_voice_allocator_core.sv =====
// Voice allocator top: controller, config registers and the row of voice cells.
// Note off, all notes off, voice finished: never busy; the first two give a registered result, finished gives none.
// Mono/legato note on: busy in the emit state, result registered from it.
// Poly note on: busy through the scan and emit states (the search walks the cell row);
// unison repeats scan and emit unison_count times (clamped to 1..8). Results cannot be stalled.
// Synchronous reset clears flags, ages, age counter and config at once.
`timescale 1ns / 1ps

module synth_voice_allocator_core #(
   parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [6:0]  req_note,
   input  logic [6:0]  req_velocity,
   input  logic [2:0]  req_voice_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_action,
   output logic [2:0]  rsp_voice,
   output logic [6:0]  rsp_note_out,
   output logic [6:0]  rsp_velocity_out,
   output logic        rsp_retrigger,
   output logic        rsp_glide,
   output logic [2:0]  rsp_spread_slot,
   output logic        rsp_spread_on,
   output logic [7:0]  rsp_release_mask,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   import sva_pkg::*;

   localparam int IDX_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CNT_W  = $clog2(NUM_VOICES + 1);
   localparam int MASK_N = (NUM_VOICES < MASK_W) ? NUM_VOICES : MASK_W;

   // configuration
   sva_mode_type     mode_ff;
   logic [CSR_W-1:0] uni_cfg_ff;
   logic             glide_on_ff;
   logic             glide_held_ff;

   sva_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       uni_ff, uni_in;
   logic [3:0]       total_ff, total_in;
   logic             direct_ff, direct_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [VEL_W-1:0] vel_ff, vel_in;
   logic [AGE_W-1:0] age_ff, age_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       action_ff, action_in;
   logic [2:0]       voice_ff, voice_in;
   logic [6:0]       note_out_ff, note_out_in;
   logic [6:0]       vel_out_ff, vel_out_in;
   logic             retrig_ff, retrig_in;
   logic             glide_ff, glide_in;
   logic [2:0]       slot_ff, slot_in;
   logic             spread_ff, spread_in;
   logic [7:0]       mask_ff, mask_in;
   logic             last_ff, last_in;

   logic             accept;
   logic             more;
   logic [3:0]       uni_sat;
   sva_ctl_type      ctl;
   logic [IDX_W-1:0] win_idx;
   logic             w_used, w_gate;

   sva_cand_type     cand [NUM_VOICES+1];
   logic [IDX_W-1:0] free_idx [NUM_VOICES+1];
   logic [IDX_W-1:0] rel_idx [NUM_VOICES+1];
   logic [IDX_W-1:0] all_idx [NUM_VOICES+1];
   sva_stat_type     stat [NUM_VOICES];
   logic [NUM_VOICES-1:0] wr_sel;
   logic [NUM_VOICES-1:0] fin_sel;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign more   = !direct_ff && ((uni_ff + 4'd1) < total_ff);

   always_comb begin
      if (uni_cfg_ff == 4'd0) begin
         uni_sat = 4'd1;
      end else if (uni_cfg_ff > 4'(UNI_MAX)) begin
         uni_sat = 4'(UNI_MAX);
      end else begin
         uni_sat = uni_cfg_ff;
      end
   end

   // seed of the search chain: nothing found, oldest age at the maximum
   assign cand[0].free_found = 1'b0;
   assign cand[0].rel_found  = 1'b0;
   assign cand[0].rel_age    = '1;
   assign cand[0].all_age    = '1;
   assign free_idx[0]        = '0;
   assign rel_idx[0]         = '0;
   assign all_idx[0]         = '0;

   for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
      assign wr_sel[g]  = (win_idx == IDX_W'(g));
      assign fin_sel[g] = (g < 8) && (req_voice_index == 3'(g));

      sva_cell #(
         .NUM_VOICES (NUM_VOICES),
         .CELL_ID    (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_sel     (wr_sel[g]),
         .fin_sel    (fin_sel[g]),
         .cand_i     (cand[g]),
         .free_idx_i (free_idx[g]),
         .rel_idx_i  (rel_idx[g]),
         .all_idx_i  (all_idx[g]),
         .cand_o     (cand[g+1]),
         .free_idx_o (free_idx[g+1]),
         .rel_idx_o  (rel_idx[g+1]),
         .all_idx_o  (all_idx[g+1]),
         .stat_o     (stat[g])
      );
   end

   // winner and its pre-start flags
   always_comb begin
      if (direct_ff) begin
         win_idx = '0;
         w_used  = stat[0].used;
         w_gate  = stat[0].gate;
      end else if (cand[NUM_VOICES].free_found) begin
         win_idx = free_idx[NUM_VOICES];
         w_used  = 1'b0;
         w_gate  = 1'b0;
      end else if (cand[NUM_VOICES].rel_found) begin
         win_idx = rel_idx[NUM_VOICES];
         w_used  = 1'b1;
         w_gate  = 1'b0;
      end else begin
         win_idx = all_idx[NUM_VOICES];
         w_used  = 1'b1;
         w_gate  = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_NOTE_ON)) begin
               if (mode_ff inside {MODE_MONO, MODE_LEGATO}) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(NUM_VOICES - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = more ? ST_SCAN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in       = cnt_ff;
      uni_in       = uni_ff;
      total_in     = total_ff;
      direct_in    = direct_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      age_in       = age_ff;
      ctl          = '0;
      ctl.note     = note_ff;
      ctl.age      = age_ff;
      rsp_valid_in = 1'b0;
      action_in    = ACT_START;
      voice_in     = '0;
      note_out_in  = '0;
      vel_out_in   = '0;
      retrig_in    = 1'b0;
      glide_in     = 1'b0;
      slot_in      = '0;
      spread_in    = 1'b0;
      mask_in      = '0;
      last_in      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            uni_in = '0;
            if (accept) begin
               note_in   = req_note;
               vel_in    = req_velocity;
               direct_in = mode_ff inside {MODE_MONO, MODE_LEGATO};
               total_in  = (mode_ff == MODE_UNISON) ? uni_sat : 4'd1;
               case (req_command)
                  CMD_NOTE_OFF: begin
                     ctl.note_off = 1'b1;
                     ctl.note     = req_note;
                     rsp_valid_in = 1'b1;
                     action_in    = ACT_RELEASE;
                     last_in      = 1'b1;
                     for (int i = 0; i < MASK_N; i++) begin
                        mask_in[i] = stat[i].off_hit;
                     end
                  end
                  CMD_ALL_OFF: begin
                     ctl.clr_all  = 1'b1;
                     rsp_valid_in = 1'b1;
                     action_in    = ACT_KILL_ALL;
                     last_in      = 1'b1;
                  end
                  CMD_FINISHED: begin
                     ctl.finish = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_EMIT: begin
            cnt_in       = '0;
            uni_in       = uni_ff + 4'd1;
            age_in       = age_ff + AGE_W'(1);
            ctl.wr_en    = 1'b1;
            rsp_valid_in = 1'b1;
            action_in    = ACT_START;
            voice_in     = 3'(win_idx);
            note_out_in  = note_ff;
            vel_out_in   = vel_ff;
            retrig_in    = direct_ff ?
                           !((mode_ff == MODE_LEGATO) && stat[0].used && stat[0].gate) : 1'b1;
            glide_in     = glide_on_ff && w_used && (!glide_held_ff || w_gate);
            slot_in      = uni_ff[2:0];
            spread_in    = (total_ff > 4'd1);
            last_in      = !more;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         uni_ff        <= '0;
         total_ff      <= 4'd1;
         direct_ff     <= 1'b0;
         age_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_POLY;
         uni_cfg_ff    <= 4'd1;
         glide_on_ff   <= 1'b0;
         glide_held_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         uni_ff       <= uni_in;
         total_ff     <= total_in;
         direct_ff    <= direct_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_VOICE_MODE:   mode_ff       <= sva_mode_type'(csr_wdata[1:0]);
               CSR_UNISON_COUNT: uni_cfg_ff    <= csr_wdata;
               CSR_GLIDE_ON:     glide_on_ff   <= csr_wdata[0];
               CSR_GLIDE_HELD:   glide_held_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      note_ff     <= note_in;
      vel_ff      <= vel_in;
      action_ff   <= action_in;
      voice_ff    <= voice_in;
      note_out_ff <= note_out_in;
      vel_out_ff  <= vel_out_in;
      retrig_ff   <= retrig_in;
      glide_ff    <= glide_in;
      slot_ff     <= slot_in;
      spread_ff   <= spread_in;
      mask_ff     <= mask_in;
      last_ff     <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_voice        = voice_ff;
   assign rsp_note_out     = note_out_ff;
   assign rsp_velocity_out = vel_out_ff;
   assign rsp_retrigger    = retrig_ff;
   assign rsp_glide        = glide_ff;
   assign rsp_spread_slot  = slot_ff;
   assign rsp_spread_on    = spread_ff;
   assign rsp_release_mask = mask_ff;
   assign rsp_last         = last_ff;

   // a start result only follows an emit cycle
   a_start_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_START)) |-> $past(state_ff == ST_EMIT))
      else $error("start request result without emit cycle");

   // the search never waits longer than the cell row
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(NUM_VOICES - 1)))
      else $error("scan counter overran");

   // poly note on always goes through a search
   a_poly_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_NOTE_ON) && (mode_ff == MODE_POLY))
      |=> (state_ff == ST_SCAN))
      else $error("poly request skipped the search");

   // unison never emits more starts than configured
   a_uni_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (uni_ff < total_ff))
      else $error("unison start count overran");

endmodule

// ===== tb/tb_synth_voice_allocator_core.sv =====
// Self-checking testbench for synth_voice_allocator_core: note events, register writes,
// an in-bench allocation predictor and an in-order check of every voice event.
// Depends on sva_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_synth_voice_allocator_core;
   import sva_pkg::*;

   localparam int NV           = 8;
   localparam int QUIET_CYCLES = 20;
   localparam int DRAIN_CYCLES = 100;
   localparam int ITEMS_PER_PH = 22;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] voice;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       retrigger;
      logic       glide;
      logic [2:0] slot;
      logic       spread;
      logic [7:0] mask;
      logic       last;
   } voice_event_type;

   typedef struct {
      bit          is_csr;
      sva_csr_type csr_idx;
      logic [3:0]  csr_val;
      sva_cmd_type cmd;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [2:0]  vidx;
      int          gap_pct;
   } stim_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_command;
   logic [6:0] req_note;
   logic [6:0] req_velocity;
   logic [2:0] req_voice_index;
   logic       rsp_valid;
   logic [1:0] rsp_action;
   logic [2:0] rsp_voice;
   logic [6:0] rsp_note_out;
   logic [6:0] rsp_velocity_out;
   logic       rsp_retrigger;
   logic       rsp_glide;
   logic [2:0] rsp_spread_slot;
   logic       rsp_spread_on;
   logic [7:0] rsp_release_mask;
   logic       rsp_last;
   logic       csr_write_en;
   logic [1:0] csr_index;
   logic [3:0] csr_wdata;

   synth_voice_allocator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_note         (req_note),
      .req_velocity     (req_velocity),
      .req_voice_index  (req_voice_index),
      .rsp_valid        (rsp_valid),
      .rsp_action       (rsp_action),
      .rsp_voice        (rsp_voice),
      .rsp_note_out     (rsp_note_out),
      .rsp_velocity_out (rsp_velocity_out),
      .rsp_retrigger    (rsp_retrigger),
      .rsp_glide        (rsp_glide),
      .rsp_spread_slot  (rsp_spread_slot),
      .rsp_spread_on    (rsp_spread_on),
      .rsp_release_mask (rsp_release_mask),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // predicted voice pool and settings
   logic         m_used [NV];
   logic         m_gate [NV];
   logic [6:0]   m_note [NV];
   logic [31:0]  m_age  [NV];
   logic [31:0]  m_age_ctr;
   sva_mode_type m_mode;
   logic [3:0]   m_uni;
   logic         m_glide_en;
   logic         m_glide_held;

   voice_event_type due_events [$];
   stim_type        stim_q [$];
   int              cur_gap;
   bit              req_taken = 1'b0;
   int              quiet_cnt = 0;
   int              err_cnt   = 0;
   int              n_on = 0, n_off = 0, n_alloff = 0, n_fin = 0;
   int              n_results = 0, n_csr = 0;

   task automatic reset_pool();
      for (int i = 0; i < NV; i++) begin
         m_used[i] = 1'b0;
         m_gate[i] = 1'b0;
         m_note[i] = '0;
         m_age[i]  = '0;
      end
      m_age_ctr    = '0;
      m_mode       = MODE_POLY;
      m_uni        = 4'd1;
      m_glide_en   = 1'b0;
      m_glide_held = 1'b0;
   endtask

   task automatic write_setting(logic [1:0] idx, logic [3:0] val);
      case (idx)
         CSR_VOICE_MODE:   m_mode = sva_mode_type'(val[1:0]);
         CSR_UNISON_COUNT: m_uni = val;
         CSR_GLIDE_ON:     m_glide_en = val[0];
         CSR_GLIDE_HELD:   m_glide_held = val[0];
         default: ;
      endcase
   endtask

   // first free voice, else oldest released, else oldest overall; ties go low
   function automatic int pick_voice();
      int best;
      bit found;
      best  = 0;
      found = 1'b0;
      for (int i = 0; i < NV; i++)
         if (!m_used[i]) return i;
      for (int i = 0; i < NV; i++)
         if (!m_gate[i] && (!found || m_age[i] < m_age[best])) begin
            best  = i;
            found = 1'b1;
         end
      if (found) return best;
      for (int i = 0; i < NV; i++)
         if (m_age[i] < m_age[best]) best = i;
      return best;
   endfunction

   task automatic start_voice(int v, logic [6:0] note, logic [6:0] vel, logic retrig,
                              logic [2:0] slot, logic spread, logic last);
      voice_event_type ev;
      ev           = '0;
      ev.action    = ACT_START;
      ev.voice     = 3'(v);
      ev.note      = note;
      ev.velocity  = vel;
      ev.retrigger = retrig;
      ev.glide     = m_glide_en && m_used[v] && (!m_glide_held || m_gate[v]);
      ev.slot      = slot;
      ev.spread    = spread;
      ev.last      = last;
      m_used[v]    = 1'b1;
      m_gate[v]    = 1'b1;
      m_note[v]    = note;
      m_age[v]     = m_age_ctr;
      m_age_ctr    = m_age_ctr + 32'd1;
      due_events.push_back(ev);
   endtask

   task automatic predict_allocation(logic [1:0] cmd, logic [6:0] note, logic [6:0] vel,
                                     logic [2:0] vidx);
      voice_event_type ev;
      bit held;
      int cnt;
      ev = '0;
      case (cmd)
         CMD_NOTE_ON: begin
            n_on++;
            case (m_mode)
               MODE_MONO, MODE_LEGATO: begin
                  held = m_used[0] && m_gate[0];
                  start_voice(0, note, vel, !(m_mode == MODE_LEGATO && held), 3'd0,
                              1'b0, 1'b1);
               end
               MODE_UNISON: begin
                  cnt = (m_uni == 4'd0) ? 1 : ((m_uni > 4'd8) ? 8 : int'(m_uni));
                  for (int i = 0; i < cnt; i++)
                     start_voice(pick_voice(), note, vel, 1'b1, 3'(i), cnt > 1,
                                 i == cnt - 1);
               end
               default: start_voice(pick_voice(), note, vel, 1'b1, 3'd0, 1'b0, 1'b1);
            endcase
         end
         CMD_NOTE_OFF: begin
            n_off++;
            ev.action = ACT_RELEASE;
            for (int i = 0; i < NV; i++)
               if (m_used[i] && m_gate[i] && m_note[i] == note) begin
                  m_gate[i]  = 1'b0;
                  ev.mask[i] = 1'b1;
               end
            ev.last = 1'b1;
            due_events.push_back(ev);
         end
         CMD_ALL_OFF: begin
            n_alloff++;
            for (int i = 0; i < NV; i++) begin
               m_used[i] = 1'b0;
               m_gate[i] = 1'b0;
            end
            ev.action = ACT_KILL_ALL;
            ev.last   = 1'b1;
            due_events.push_back(ev);
         end
         default: begin
            n_fin++;
            if (m_used[vidx] && !m_gate[vidx]) m_used[vidx] = 1'b0;
         end
      endcase
   endtask

   function automatic string fmt_event(voice_event_type e);
      return {$sformatf("act=%0d voice=%0d note=%0d vel=%0d ",
                        e.action, e.voice, e.note, e.velocity),
              $sformatf("rt=%0b gl=%0b slot=%0d spr=%0b mask=%02h last=%0b",
                        e.retrigger, e.glide, e.slot, e.spread, e.mask, e.last)};
   endfunction

   // ---------------- stimulus building
   task automatic add_req(sva_cmd_type cmd, logic [6:0] note, logic [6:0] vel,
                          logic [2:0] vidx);
      stim_type s;
      s.is_csr   = 1'b0;
      s.csr_idx  = CSR_VOICE_MODE;
      s.csr_val  = '0;
      s.cmd      = cmd;
      s.note     = note;
      s.velocity = vel;
      s.vidx     = vidx;
      s.gap_pct  = cur_gap;
      stim_q.push_back(s);
   endtask

   task automatic add_csr(sva_csr_type idx, logic [3:0] val);
      stim_type s;
      s.is_csr   = 1'b1;
      s.csr_idx  = idx;
      s.csr_val  = val;
      s.cmd      = CMD_NOTE_ON;
      s.note     = '0;
      s.velocity = '0;
      s.vidx     = '0;
      s.gap_pct  = 0;
      stim_q.push_back(s);
   endtask

   task automatic add_note_on(logic [6:0] note);
      add_req(CMD_NOTE_ON, note, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
   endtask

   task automatic add_note_off(logic [6:0] note);
      add_req(CMD_NOTE_OFF, note, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
   endtask

   // one setting of the registers, then random note traffic over a small note pool
   task automatic add_phase(sva_mode_type mode, logic [3:0] uni, logic glide, logic held,
                            int gap);
      logic [6:0] pool [6];
      int made;
      int roll;
      logic [6:0] nt;
      add_csr(CSR_VOICE_MODE, {2'($urandom_range(0, 3)), mode});
      add_csr(CSR_UNISON_COUNT, uni);
      add_csr(CSR_GLIDE_ON, {3'($urandom_range(0, 7)), glide});
      add_csr(CSR_GLIDE_HELD, {3'($urandom_range(0, 7)), held});
      cur_gap = gap;
      for (int i = 0; i < 6; i++) pool[i] = 7'($urandom_range(0, 127));
      made = 0;
      while (made < ITEMS_PER_PH) begin
         roll = $urandom_range(0, 99);
         nt   = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)]
                                             : 7'($urandom_range(0, 127));
         if (roll < 45) begin
            add_note_on(nt);
            made++;
         end else if (roll < 75) begin
            add_note_off(nt);
            made++;
         end else if (roll < 80) begin
            add_req(CMD_ALL_OFF, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    3'($urandom_range(0, 7)));
            made++;
         end else begin
            add_req(CMD_FINISHED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    3'($urandom_range(0, 7)));
            made++;
         end
      end
   endtask

   // ---------------- clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- request and register driver
   always @(negedge clock) begin
      logic nxt_start;
      logic nxt_wen;
      stim_type s;
      nxt_start = start;
      nxt_wen   = 1'b0;
      if (req_taken) begin
         nxt_start = 1'b0;
         req_taken = 1'b0;
         quiet_cnt = 0;
      end else if (quiet_cnt < QUIET_CYCLES) begin
         quiet_cnt++;
      end
      if (!reset && !nxt_start && stim_q.size() > 0) begin
         if (stim_q[0].is_csr) begin
            // settings change only with the pool idle and every event in
            if (due_events.size() == 0 && !busy && quiet_cnt >= QUIET_CYCLES) begin
               s = stim_q.pop_front();
               nxt_wen = 1'b1;
               csr_index <= s.csr_idx;
               csr_wdata <= s.csr_val;
            end
         end else if ($urandom_range(0, 99) >= stim_q[0].gap_pct) begin
            s = stim_q.pop_front();
            nxt_start = 1'b1;
            req_command     <= s.cmd;
            req_note        <= s.note;
            req_velocity    <= s.velocity;
            req_voice_index <= s.vidx;
         end
      end
      start        <= nxt_start;
      csr_write_en <= nxt_wen;
   end

   // ---------------- result checker and request predictor
   always @(posedge clock) begin
      voice_event_type got;
      voice_event_type want;
      if (reset) begin
         reset_pool();
      end else begin
         if (rsp_valid) begin
            n_results++;
            got = {rsp_action, rsp_voice, rsp_note_out, rsp_velocity_out, rsp_retrigger,
                   rsp_glide, rsp_spread_slot, rsp_spread_on, rsp_release_mask, rsp_last};
            if (due_events.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("ERROR %0t: unexpected event %s", $time, fmt_event(got));
            end else begin
               want = due_events.pop_front();
               if (got !== want) begin
                  err_cnt++;
                  if (err_cnt <= 10) begin
                     $display("ERROR %0t: event mismatch", $time);
                     $display("   expected %s", fmt_event(want));
                     $display("   actual   %s", fmt_event(got));
                  end
               end
            end
         end
         if (csr_write_en) begin
            n_csr++;
            write_setting(csr_index, csr_wdata);
         end
         if (start && !busy) begin
            predict_allocation(req_command, req_note, req_velocity, req_voice_index);
            req_taken = 1'b1;
         end
      end
   end

   // ---------------- sequence and end of run
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_command     = CMD_NOTE_ON;
      req_note        = '0;
      req_velocity    = '0;
      req_voice_index = '0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_VOICE_MODE;
      csr_wdata       = '0;
      cur_gap         = 19;

      // directed, poly at reset settings
      add_note_off(7'd60);                       // release with nothing held
      add_req(CMD_FINISHED, 7'd0, 7'd0, 3'd0);   // finish on unused voice
      add_req(CMD_NOTE_ON, 7'd0, 7'd127, 3'd7);
      add_req(CMD_NOTE_ON, 7'd127, 7'd0, 3'd0);
      add_note_on(7'd60);
      add_note_on(7'd62);
      add_note_on(7'd64);
      add_note_on(7'd65);
      add_note_on(7'd67);
      add_note_on(7'd69);
      add_note_on(7'd72);                        // pool full and all held: oldest steal
      add_note_off(7'd62);
      add_note_off(7'd127);
      add_note_on(7'd48);                        // oldest released voice wins
      add_req(CMD_FINISHED, 7'd0, 7'd0, 3'd3);   // released voice goes free
      add_req(CMD_FINISHED, 7'd0, 7'd0, 3'd4);   // still gated, no effect
      add_note_on(7'd50);
      add_note_on(7'd50);
      add_note_off(7'd50);                       // two voices in one mask
      add_req(CMD_ALL_OFF, 7'd127, 7'd127, 3'd7);
      // legato with held-only glide, then a wide unison
      add_csr(CSR_VOICE_MODE, {2'b00, MODE_LEGATO});
      add_csr(CSR_GLIDE_ON, 4'd1);
      add_csr(CSR_GLIDE_HELD, 4'd1);
      add_note_on(7'd40);
      add_note_on(7'd41);
      add_note_off(7'd41);
      add_note_on(7'd42);
      add_csr(CSR_VOICE_MODE, {2'b11, MODE_UNISON});
      add_csr(CSR_UNISON_COUNT, 4'd15);
      add_note_on(7'd30);

      // random part: sender gaps 19%, then 85%, then none
      add_phase(MODE_POLY,   4'd1,  1'b1, 1'b0, 19);
      add_phase(MODE_MONO,   4'd0,  1'b1, 1'b1, 19);
      add_phase(MODE_LEGATO, 4'd15, 1'b1, 1'b0, 19);
      add_phase(MODE_UNISON, 4'd2,  1'b0, 1'b0, 85);
      add_phase(MODE_UNISON, 4'd8,  1'b1, 1'b1, 85);
      add_phase(MODE_LEGATO, 4'd3,  1'b0, 1'b1, 85);
      add_phase(MODE_POLY,   4'd15, 1'b1, 1'b1, 0);
      add_phase(MODE_UNISON, 4'd0,  1'b1, 1'b0, 0);
      add_phase(MODE_UNISON, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || start || due_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d note on, %0d note off, %0d all notes off, %0d voice finished",
               n_on, n_off, n_alloff, n_fin);
      $display("%0d voice events checked over %0d register writes, %0d mismatches",
               n_results, n_csr, err_cnt);
      if (err_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout: %0d requests still queued, %0d events outstanding",
               stim_q.size(), due_events.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
